// ----- sv/url_escaped_base64_decoder_defines.svh -----
// assertion helpers shared by the decoder modules
`ifndef URL_ESCAPED_BASE64_DECODER_DEFINES_SVH
`define URL_ESCAPED_BASE64_DECODER_DEFINES_SVH

// expression must hold at every clock edge out of reset
`define UED_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define UED_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- sv/ued_pkg.sv -----
package ued_pkg;

  localparam int unsigned MAX_OUTPUT_BYTES = 1024;
  localparam int unsigned CfgW = 11;
  localparam int unsigned CntW = $clog2(MAX_OUTPUT_BYTES + 1);
  localparam int unsigned LimW = (CntW > CfgW) ? CntW : CfgW;
  localparam logic [CfgW-1:0] LenReset = CfgW'(287);

  // result queue, power of two deep, at least three entries
  localparam int unsigned FifoDepth = 8;

  localparam logic [7:0] CharPct = 8'h25;
  localparam logic [7:0] CharAmp = 8'h26;
  localparam logic [6:0] SextetPad = 7'd64;
  localparam logic [6:0] SextetNone = 7'd65;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_AMP = 2'd1,
    ST_CUT = 2'd2
  } ued_status_e;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HEX1 = 2'd1,
    ESC_HEX2 = 2'd2
  } ued_esc_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_first;
    logic       is_last;
  } ued_in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       finished;
    logic [1:0] status;
  } ued_out_t;

  // results of one character, count valid entries from index 0
  typedef struct packed {
    logic [1:0]     count;
    ued_out_t [2:0] res;
  } ued_grp_t;

  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] s;
    if (c >= 8'h41 && c <= 8'h5a) s = 7'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7a) s = 7'(c - 8'h61 + 8'd26);
    else if (c >= 8'h30 && c <= 8'h39) s = 7'(c - 8'h30 + 8'd52);
    else if (c == 8'h2b) s = 7'd62;
    else if (c == 8'h2f) s = 7'd63;
    else if (c == 8'h3d) s = SextetPad;
    else s = SextetNone;
    return s;
  endfunction

  // bit 4 is the valid flag, bits 3:0 the nibble
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] h;
    if (c >= 8'h30 && c <= 8'h39) h = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) h = {1'b1, 4'(c - 8'h61 + 8'd10)};
    else if (c >= 8'h41 && c <= 8'h46) h = {1'b1, 4'(c - 8'h41 + 8'd10)};
    else h = 5'd0;
    return h;
  endfunction

endpackage

// ----- sv/url_escaped_base64_decoder.sv -----
// channel  | direction | signals                          | transfer when
// ---------+-----------+----------------------------------+-----------------------------
// in       | input     | in_valid_i in_ready_o in_data_i  | in_valid_i and in_ready_o
// out      | output    | out_valid_o out_ready_i out_data_o | out_valid_o and out_ready_i
// cfg      | input     | cfg_we_i cfg_data_i              | cfg_we_i, no wait
//
// one character per cycle unless stalled; results leave one per cycle from an eight entry queue
// with an empty queue a character's first result passes the input register and then the queue
// before it can transfer; input stalls only while the queue has fewer than three free entries
// reset clears control state, sets output_length to 287 and idles until a first character
// no clearing pass after reset

module url_escaped_base64_decoder (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  ued_pkg::ued_in_t         in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output ued_pkg::ued_out_t        out_data_o,
  input  logic                     cfg_we_i,
  input  logic [ued_pkg::CfgW-1:0] cfg_data_i
);
  import ued_pkg::*;

  // input register
  logic            in_valid_q;
  ued_in_t         in_q;
  // configured byte count
  logic [CfgW-1:0] len_q;

  logic            room;
  logic            step_en;
  ued_grp_t        grp;

  // the held character is decoded once the queue can take all its results
  assign step_en    = in_valid_q && room;
  // a new character enters as soon as the held one moves on
  assign in_ready_o = !in_valid_q || step_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenReset;
    end else if (cfg_we_i) begin
      len_q <= cfg_data_i;
    end
  end

  // escape handling, sextet assembly and byte forming
  ued_decoder u_decoder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .item_i    (in_q),
    .len_i     (len_q),
    .grp_o     (grp)
  );

  // result queue, also the output register
  ued_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step_en),
    .grp_i       (grp),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- sv/ued_decoder.sv -----
`include "url_escaped_base64_decoder_defines.svh"

module ued_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_en_i,
  input  ued_pkg::ued_in_t            item_i,
  input  logic [ued_pkg::CfgW-1:0]    len_i,
  output ued_pkg::ued_grp_t           grp_o
);
  import ued_pkg::*;

  logic [6:0]      store_q [3];
  logic [6:0]      store_d [3];
  logic [1:0]      cnt_q, cnt_d;
  ued_esc_e        phase_q, phase_d;
  logic [3:0]      nib_q, nib_d;
  logic            nib_ok_q, nib_ok_d;
  logic [CntW-1:0] be_q, be_d;
  logic            done_q, done_d;

  // state as seen after a possible restart
  logic [6:0]      e_store [3];
  logic [1:0]      e_cnt;
  ued_esc_e        e_phase;
  logic [3:0]      e_nib;
  logic            e_nib_ok;
  logic [CntW-1:0] e_be;
  logic            e_done;

  logic [4:0]      hex;
  logic [6:0]      sx_raw, sx_esc, push_v;
  logic [LimW-1:0] lim, lim_raw;
  logic [LimW:0]   be_ext, lim_ext;
  logic            push, early, fin;
  logic [1:0]      n;
  logic [8:0]      t0;
  logic [10:0]     t1;
  logic [12:0]     t2;
  logic            any_fin;
  logic            idle_in;
  logic            err_res;

  always_comb begin
    if (item_i.is_first) begin
      for (int k = 0; k < 3; k++) e_store[k] = '0;
      e_cnt    = '0;
      e_phase  = ESC_NONE;
      e_nib    = '0;
      e_nib_ok = 1'b0;
      e_be     = '0;
      e_done   = 1'b0;
    end else begin
      for (int k = 0; k < 3; k++) e_store[k] = store_q[k];
      e_cnt    = cnt_q;
      e_phase  = phase_q;
      e_nib    = nib_q;
      e_nib_ok = nib_ok_q;
      e_be     = be_q;
      e_done   = done_q;
    end
  end

  assign hex    = hex_value(item_i.char_byte);
  assign sx_raw = sextet_of(item_i.char_byte);
  assign sx_esc = sextet_of({e_nib, hex[3:0]});

  // zero acts as one, clamp at the maximum
  assign lim_raw = (len_i == '0) ? LimW'(1) : LimW'(len_i);
  assign lim     = (lim_raw > LimW'(MAX_OUTPUT_BYTES)) ? LimW'(MAX_OUTPUT_BYTES) : lim_raw;
  assign be_ext  = (LimW + 1)'(e_be);
  assign lim_ext = {1'b0, lim};

  assign t0 = {e_store[0], 2'b00} | {6'b0, e_store[1][6:4]};
  assign t1 = {e_store[1], 4'b0000} | {6'b0, e_store[2][6:2]};
  assign t2 = {e_store[2], 6'b000000} | {6'b0, push_v};

  // escape phase sequencing
  always_comb begin
    phase_d = e_phase;
    if (!e_done) begin
      unique case (e_phase)
        ESC_HEX1: phase_d = ESC_HEX2;
        ESC_HEX2: phase_d = ESC_NONE;
        ESC_NONE: phase_d = (item_i.char_byte == CharPct) ? ESC_HEX1 : ESC_NONE;
        default:  phase_d = ESC_NONE;
      endcase
    end
  end

  // sextet handling and results
  always_comb begin
    for (int k = 0; k < 3; k++) store_d[k] = e_store[k];
    cnt_d    = e_cnt;
    be_d     = e_be;
    nib_d    = e_nib;
    nib_ok_d = e_nib_ok;
    done_d   = e_done;
    grp_o    = '0;
    push     = 1'b0;
    push_v   = sx_raw;
    early    = 1'b0;
    fin      = 1'b0;
    n        = 2'd0;
    if (!e_done) begin
      unique case (e_phase)
        ESC_HEX1: begin
          nib_ok_d = hex[4];
          nib_d    = hex[3:0];
          early    = 1'b1;
          if (item_i.is_last) begin
            done_d = 1'b1;
            n      = 2'd1;
            grp_o.res[0].finished = 1'b1;
            grp_o.res[0].status   = ST_CUT;
          end
        end
        ESC_HEX2: begin
          if (hex[4] && e_nib_ok && sx_esc != SextetNone) begin
            push   = 1'b1;
            push_v = sx_esc;
          end
        end
        default: begin
          if (item_i.char_byte == CharPct) begin
            early = 1'b1;
            if (item_i.is_last) begin
              done_d = 1'b1;
              n      = 2'd1;
              grp_o.res[0].finished = 1'b1;
              grp_o.res[0].status   = ST_CUT;
            end
          end else if (item_i.char_byte == CharAmp) begin
            early  = 1'b1;
            done_d = 1'b1;
            n      = 2'd1;
            grp_o.res[0].finished = 1'b1;
            grp_o.res[0].status   = ST_AMP;
          end else if (sx_raw != SextetNone) begin
            push = 1'b1;
          end
        end
      endcase

      if (push) begin
        if (e_cnt != 2'd3) begin
          store_d[e_cnt] = push_v;
          cnt_d          = e_cnt + 2'd1;
        end else begin
          cnt_d = 2'd0;
          n     = 2'd1;
          grp_o.res[0].data_byte = t0[7:0];
          grp_o.res[0].has_byte  = 1'b1;
          if (be_ext + 1'b1 >= lim_ext) begin
            fin = 1'b1;
          end else if (e_store[2] < SextetPad) begin
            n = 2'd2;
            grp_o.res[1].data_byte = t1[7:0];
            grp_o.res[1].has_byte  = 1'b1;
            if (be_ext + 2'd2 >= lim_ext) begin
              fin = 1'b1;
            end else if (push_v < SextetPad) begin
              n = 2'd3;
              grp_o.res[2].data_byte = t2[7:0];
              grp_o.res[2].has_byte  = 1'b1;
              if (be_ext + 2'd3 >= lim_ext) fin = 1'b1;
            end
          end
          be_d = e_be + CntW'(n);
        end
      end

      if (!early && (fin || item_i.is_last)) begin
        done_d = 1'b1;
        if (n != 2'd0) begin
          grp_o.res[n - 2'd1].finished = 1'b1;
        end else begin
          n = 2'd1;
          grp_o.res[0].finished = 1'b1;
          grp_o.res[0].status   = ST_OK;
        end
      end
    end
    grp_o.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) store_q[k] <= '0;
      cnt_q    <= '0;
      phase_q  <= ESC_NONE;
      nib_q    <= '0;
      nib_ok_q <= 1'b0;
      be_q     <= '0;
      done_q   <= 1'b1;
    end else if (step_en_i) begin
      for (int k = 0; k < 3; k++) store_q[k] <= store_d[k];
      cnt_q    <= cnt_d;
      phase_q  <= phase_d;
      nib_q    <= nib_d;
      nib_ok_q <= nib_ok_d;
      be_q     <= be_d;
      done_q   <= done_d;
    end
  end

  assign any_fin = (grp_o.count != 2'd0) && grp_o.res[grp_o.count - 2'd1].finished;
  assign idle_in = step_en_i && done_q && !item_i.is_first;
  assign err_res = step_en_i && (grp_o.res[0].status != ST_OK);

  `UED_ASSERT_NEXT(a_fin_sets_done, step_en_i && any_fin, done_q, "finish did not end the value")
  `UED_ASSERT(a_idle_silent, !idle_in || grp_o.count == 2'd0, "result while idle")
  `UED_ASSERT(a_err_alone, !err_res || (grp_o.count == 2'd1 && !grp_o.res[0].has_byte), "error with byte")

endmodule

// ----- sv/ued_res_fifo.sv -----
`include "url_escaped_base64_decoder_defines.svh"

module ued_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ued_pkg::ued_grp_t  grp_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ued_pkg::ued_out_t  out_data_o
);
  import ued_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned FillW = $clog2(FifoDepth + 1);

  ued_out_t         mem_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [1:0]       n_push;
  logic             pop;
  logic             pop_only;

  assign n_push      = push_i ? grp_i.count : 2'd0;
  assign pop         = out_valid_o && out_ready_i;
  assign pop_only    = pop && (n_push == 2'd0);
  assign out_valid_o = (fill_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  // space for a full group of three
  assign room_o      = (fill_q <= FillW'(FifoDepth - 3));

  assign wr_ptr_d = wr_ptr_q + PtrW'(n_push);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign fill_d   = fill_q + FillW'(n_push) - FillW'(pop);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (k < int'(n_push)) mem_q[wr_ptr_q + PtrW'(k)] <= grp_i.res[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  `UED_ASSERT(a_fill_bound, fill_q <= FillW'(FifoDepth), "result queue overflow")
  `UED_ASSERT(a_push_room, !push_i || room_o, "push without room for a group")
  `UED_ASSERT_NEXT(a_pop_only, pop_only, fill_q == $past(fill_q) - 1'b1, "fill off after pop")

endmodule
